// File: hw/rtl/mtks_pkg.sv
package mtks_pkg;

    // action codes carried in action_kind
    localparam logic [2:0] KIND_TAP       = 3'd0;
    localparam logic [2:0] KIND_HOLD      = 3'd1;
    localparam logic [2:0] KIND_INTERRUPT = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd3;
    localparam logic [2:0] KIND_RELEASE   = 3'd4;

    // configuration register indexes
    localparam logic CFG_FIRST_CODE    = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd40;

    typedef struct packed {
        logic        op;
        logic [15:0] key_code;
        logic        now_down;
        logic        was_down;
        logic        injected;
    } t_in_item;

    typedef struct packed {
        logic       is_action;
        logic [4:0] key_index;
        logic [7:0] tap_count;
        logic [2:0] action_kind;
        logic       forward_key;
        logic       last_item;
    } t_out_item;

    // sequence state, plus a copy of the active key's tap count
    typedef struct packed {
        logic        active;
        logic [4:0]  index;
        logic [7:0]  count;
        logic [15:0] timer;
    } t_seq;

    function automatic t_out_item mk_act(logic [4:0] idx, logic [7:0] cnt,
                                         logic [2:0] kind);
        t_out_item r;
        r             = '0;
        r.is_action   = 1'b1;
        r.key_index   = idx;
        r.tap_count   = cnt;
        r.action_kind = kind;
        return r;
    endfunction

endpackage

// File: hw/rtl/mtks_step.sv
module mtks_step #(
    parameter int NUM_TAP_KEYS = 32
) (
    input  logic [15:0]                 i_first_code,
    input  logic [15:0]                 i_timeout_ticks,
    input  mtks_pkg::t_in_item          i_item,
    input  mtks_pkg::t_seq              i_seq,
    input  logic [7:0]                  i_count,
    output logic [4:0]                  o_idx,
    output mtks_pkg::t_seq              o_seq,
    output logic                        o_cnt_we,
    output logic [7:0]                  o_cnt_wdata,
    output mtks_pkg::t_out_item [2:0]   o_res,
    output logic [1:0]                  o_res_cnt
);

    logic [16:0]         diff;
    logic                is_tap;
    logic                on;
    logic                off;
    logic                fwd;
    logic [1:0]          nact;
    logic [7:0]          cnt_inc;
    logic [15:0]         timer_n;
    mtks_pkg::t_out_item act0;
    mtks_pkg::t_out_item act1;
    mtks_pkg::t_out_item verdict;

    assign diff    = {1'b0, i_item.key_code} - {1'b0, i_first_code};
    assign is_tap  = !diff[16] && (diff[15:0] < 16'(NUM_TAP_KEYS));
    assign o_idx   = diff[4:0];
    assign on      = i_item.now_down && !i_item.was_down;
    assign off     = !i_item.now_down && i_item.was_down;
    assign cnt_inc = i_count + 8'd1;
    assign timer_n = (i_seq.timer < i_timeout_ticks) ? i_seq.timer + 16'd1 : i_seq.timer;

    always_comb begin
        o_seq       = i_seq;
        o_cnt_we    = 1'b0;
        o_cnt_wdata = cnt_inc;
        nact        = 2'd0;
        fwd         = 1'b0;
        act0        = '0;
        act1        = '0;
        if (i_item.op) begin
            if (i_seq.active) begin
                o_seq.timer = timer_n;
                if (timer_n >= i_timeout_ticks) begin
                    act0         = mtks_pkg::mk_act(i_seq.index, i_seq.count,
                                                    mtks_pkg::KIND_TIMEOUT);
                    o_seq.active = 1'b0;
                    nact         = 2'd1;
                end
            end
        end else if (i_item.injected) begin
            fwd = 1'b1;
        end else if (!i_item.now_down && !i_item.was_down) begin
            fwd = !is_tap;
        end else if (!is_tap) begin
            fwd = 1'b1;
            if (i_seq.active && on) begin
                act0         = mtks_pkg::mk_act(i_seq.index, i_seq.count,
                                                mtks_pkg::KIND_INTERRUPT);
                o_seq.active = 1'b0;
                nact         = 2'd1;
            end
        end else if (!i_seq.active) begin
            // idle key: any down, held or released event starts with a tap
            act0         = mtks_pkg::mk_act(o_idx, cnt_inc, mtks_pkg::KIND_TAP);
            o_seq.active = 1'b1;
            o_seq.index  = o_idx;
            o_seq.count  = cnt_inc;
            o_seq.timer  = '0;
            o_cnt_we     = 1'b1;
            nact         = 2'd1;
        end else if (i_seq.index != o_idx) begin
            if (off && i_count != 8'd0) begin
                act0        = mtks_pkg::mk_act(o_idx, i_count, mtks_pkg::KIND_RELEASE);
                o_cnt_we    = 1'b1;
                o_cnt_wdata = 8'd0;
                nact        = 2'd1;
            end else if (on) begin
                act0         = mtks_pkg::mk_act(i_seq.index, i_seq.count,
                                                mtks_pkg::KIND_INTERRUPT);
                act1         = mtks_pkg::mk_act(o_idx, cnt_inc, mtks_pkg::KIND_TAP);
                o_seq.active = 1'b1;
                o_seq.index  = o_idx;
                o_seq.count  = cnt_inc;
                o_seq.timer  = '0;
                o_cnt_we     = 1'b1;
                nact         = 2'd2;
            end
        end else if (on) begin
            act0        = mtks_pkg::mk_act(o_idx, cnt_inc, mtks_pkg::KIND_TAP);
            o_seq.count = cnt_inc;
            o_seq.timer = '0;
            o_cnt_we    = 1'b1;
            nact        = 2'd1;
        end else if (!off) begin
            act0 = mtks_pkg::mk_act(o_idx, i_count, mtks_pkg::KIND_HOLD);
            nact = 2'd1;
        end
    end

    always_comb begin
        verdict             = '0;
        verdict.forward_key = fwd;
        verdict.last_item   = 1'b1;
        o_res               = '0;
        if (i_item.op) begin
            o_res[0]           = act0;
            o_res[0].last_item = 1'b1;
            o_res_cnt          = nact;
        end else begin
            case (nact)
                2'd0: begin
                    o_res[0] = verdict;
                end
                2'd1: begin
                    o_res[0] = act0;
                    o_res[1] = verdict;
                end
                default: begin
                    o_res[0] = act0;
                    o_res[1] = act1;
                    o_res[2] = verdict;
                end
            endcase
            o_res_cnt = nact + 2'd1;
        end
    end

endmodule

// File: hw/rtl/multi_tap_key_sequencer.sv
// Multi-tap key sequencer. An input item (key event or tick) is taken into an
// input register, then decoded against the sequence state and the per-key tap
// counts, and its zero to three results are loaded into a result buffer that
// the output drains one transfer per cycle while i_stall is low. A tick that
// causes no result leaves the buffer empty. The next item is taken into the
// input register while results still wait, and is decoded as the last of them
// leaves; the single result port thus limits how fast items go through.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write it only while the block is idle; the block itself does not
// enforce it.
module multi_tap_key_sequencer #(
    parameter int NUM_TAP_KEYS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mtks_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output mtks_pkg::t_out_item o_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam int IW = (NUM_TAP_KEYS > 1) ? $clog2(NUM_TAP_KEYS) : 1;

    logic [15:0]                    r_first_code;
    logic [15:0]                    r_timeout_ticks;
    mtks_pkg::t_seq                 r_seq;
    logic [7:0]                     r_taps [NUM_TAP_KEYS];
    logic                           r_in_valid;
    mtks_pkg::t_in_item             r_in;
    mtks_pkg::t_out_item [2:0]      r_res;
    logic [1:0]                     r_head;
    logic [1:0]                     r_left;

    logic [4:0]                     idx;
    mtks_pkg::t_seq                 n_seq;
    logic                           cnt_we;
    logic [7:0]                     cnt_wdata;
    mtks_pkg::t_out_item [2:0]      n_res;
    logic [1:0]                     n_res_cnt;
    logic                           pop;
    logic                           process;

    mtks_step #(
        .NUM_TAP_KEYS(NUM_TAP_KEYS)
    ) u_step (
        .i_first_code   (r_first_code),
        .i_timeout_ticks(r_timeout_ticks),
        .i_item         (r_in),
        .i_seq          (r_seq),
        .i_count        (r_taps[idx[IW-1:0]]),
        .o_idx          (idx),
        .o_seq          (n_seq),
        .o_cnt_we       (cnt_we),
        .o_cnt_wdata    (cnt_wdata),
        .o_res          (n_res),
        .o_res_cnt      (n_res_cnt)
    );

    assign o_valid = (r_left != 2'd0);
    assign o_data  = r_res[r_head];
    assign pop     = o_valid && !i_stall;
    assign process = r_in_valid && ((r_left == 2'd0) || (r_left == 2'd1 && pop));
    assign o_stall = r_in_valid && !process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_code    <= '0;
            r_timeout_ticks <= mtks_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mtks_pkg::CFG_FIRST_CODE:    r_first_code    <= i_cfg_data;
                mtks_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
            for (int i = 0; i < NUM_TAP_KEYS; i++) begin
                r_taps[i] <= 8'd0;
            end
        end else if (process) begin
            r_seq <= n_seq;
            if (cnt_we) begin
                r_taps[idx[IW-1:0]] <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_left <= '0;
        end else if (process) begin
            r_head <= 2'd0;
            r_left <= n_res_cnt;
        end else if (pop) begin
            r_head <= r_head + 2'd1;
            r_left <= r_left - 2'd1;
        end
        if (process) begin
            r_res <= n_res;
        end
    end

    // the final result of an item is the last one in the buffer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.last_item) |-> (r_left == 2'd1))
        else $error("last_item shown with results still queued");

    // a verdict always closes its item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.is_action) |-> o_data.last_item)
        else $error("verdict not marked last");

    // a sequence only starts from a processed item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_seq.active) |-> $past(process))
        else $error("sequence started without an item");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 23;
    localparam int IN_W        = $bits(mtks_pkg::t_in_item);

    typedef struct packed {
        bit                          pinned;
        logic [1:0]                  n;
        mtks_pkg::t_out_item [2:0]   r;
    } t_pin;

    typedef struct packed {
        bit                 is_cfg;
        logic               cfg_idx;
        logic [15:0]        cfg_val;
        mtks_pkg::t_in_item item;
        t_pin               pin;
    } t_step;

    localparam mtks_pkg::t_out_item NIL = '0;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    mtks_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_stall;
    mtks_pkg::t_out_item o_data;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [15:0]         i_cfg_data;

    multi_tap_key_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // sequencer model state
    logic [15:0]               base_code;
    logic [15:0]               tmo_ticks;
    logic                      seq_on;
    logic [4:0]                act_idx;
    logic [15:0]               idle_tmr;
    logic [7:0]                taps [32];
    mtks_pkg::t_out_item [2:0] res_buf;
    int                        res_n;

    mtks_pkg::t_out_item pending_reports [$];
    t_pin                pin_q [$];
    t_step               plan [$];
    bit                  calm;
    int                  ev_sent;
    int                  errs;
    int                  cycles;

    function automatic void emit(input logic act, input logic [4:0] idx,
                                 input logic [7:0] cnt, input logic [2:0] kind,
                                 input logic fwd);
        mtks_pkg::t_out_item r;
        r             = '0;
        r.is_action   = act;
        r.key_index   = idx;
        r.tap_count   = cnt;
        r.action_kind = kind;
        r.forward_key = fwd;
        res_buf[res_n] = r;
        res_n++;
    endfunction

    function automatic void report_key(input logic [4:0] idx, input logic [2:0] kind);
        emit(1'b1, idx, taps[idx], kind, 1'b0);
    endfunction

    function automatic void count_tap();
        taps[act_idx] = taps[act_idx] + 8'd1;
        idle_tmr      = '0;
        report_key(act_idx, mtks_pkg::KIND_TAP);
    endfunction

    function automatic void close_seq(input logic [2:0] kind);
        report_key(act_idx, kind);
        seq_on = 1'b0;
    endfunction

    // returns the forward verdict of a key event
    function automatic logic judge_event(input mtks_pkg::t_in_item it);
        logic        on;
        logic        off;
        logic        in_win;
        logic [16:0] offs;
        logic [4:0]  idx;
        on     = it.now_down && !it.was_down;
        off    = !it.now_down && it.was_down;
        offs   = {1'b0, it.key_code} - {1'b0, base_code};
        in_win = (it.key_code >= base_code) && (offs < 17'd32);
        idx    = offs[4:0];
        if (it.injected)
            return 1'b1;
        if (!it.now_down && !it.was_down)
            return !in_win;
        if (!in_win) begin
            if (seq_on && on)
                close_seq(mtks_pkg::KIND_INTERRUPT);
            return 1'b1;
        end
        if (!(seq_on && act_idx == idx)) begin
            if (!seq_on) begin
                seq_on  = 1'b1;
                act_idx = idx;
                count_tap();
                return 1'b0;
            end
            if (off && taps[idx] != 8'd0) begin
                report_key(idx, mtks_pkg::KIND_RELEASE);
                taps[idx] = '0;
                return 1'b0;
            end
            if (!on)
                return 1'b0;
            close_seq(mtks_pkg::KIND_INTERRUPT);
        end
        if (off)
            return 1'b0;
        seq_on  = 1'b1;
        act_idx = idx;
        if (on) begin
            count_tap();
            return 1'b0;
        end
        report_key(idx, mtks_pkg::KIND_HOLD);
        return 1'b0;
    endfunction

    function automatic void step_sequencer(input mtks_pkg::t_in_item it);
        logic fwd;
        res_n = 0;
        if (it.op) begin
            if (seq_on) begin
                if (idle_tmr < tmo_ticks)
                    idle_tmr = idle_tmr + 16'd1;
                if (idle_tmr >= tmo_ticks)
                    close_seq(mtks_pkg::KIND_TIMEOUT);
            end
        end else begin
            fwd = judge_event(it);
            emit(1'b0, '0, '0, '0, fwd);
        end
        if (res_n > 0)
            res_buf[res_n - 1].last_item = 1'b1;
    endfunction

    function automatic void reset_model();
        base_code = '0;
        tmo_ticks = mtks_pkg::TIMEOUT_RESET;
        seq_on    = 1'b0;
        act_idx   = '0;
        idle_tmr  = '0;
        for (int k = 0; k < 32; k++)
            taps[k] = '0;
    endfunction

    function automatic string fmt(input mtks_pkg::t_out_item r);
        return $sformatf("act=%0d idx=%0d cnt=%0d kind=%0d fwd=%0d last=%0d",
                         r.is_action, r.key_index, r.tap_count, r.action_kind,
                         r.forward_key, r.last_item);
    endfunction

    // check results, track accepted items, randomize the output stall
    always @(posedge i_clk) begin
        mtks_pkg::t_out_item want;
        t_pin                pin;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else if (!i_rst_n) begin
            reset_model();
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_reports.size() == 0) begin
                    if (errs < 10)
                        $display("unexpected transfer: %s", fmt(o_data));
                    errs++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_data.is_action !== want.is_action ||
                        o_data.key_index !== want.key_index ||
                        o_data.tap_count !== want.tap_count ||
                        o_data.action_kind !== want.action_kind ||
                        o_data.forward_key !== want.forward_key ||
                        o_data.last_item !== want.last_item) begin
                        if (errs < 10)
                            $display("mismatch: exp %s / got %s", fmt(want), fmt(o_data));
                        errs++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mtks_pkg::CFG_FIRST_CODE:    base_code = i_cfg_data;
                    mtks_pkg::CFG_TIMEOUT_TICKS: tmo_ticks = i_cfg_data;
                endcase
            end
            if (i_valid && !o_stall) begin
                pin = pin_q.pop_front();
                step_sequencer(i_data);
                if (pin.pinned) begin
                    for (int k = 0; k < pin.n; k++)
                        pending_reports.push_back(pin.r[k]);
                end else begin
                    for (int k = 0; k < res_n; k++)
                        pending_reports.push_back(res_buf[k]);
                end
            end
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic mtks_pkg::t_in_item key_ev(input logic [15:0] code, input logic now,
                                                  input logic was, input logic inj);
        mtks_pkg::t_in_item it;
        it          = '0;
        it.key_code = code;
        it.now_down = now;
        it.was_down = was;
        it.injected = inj;
        return it;
    endfunction

    // other fields of a tick are don't-care, so fill them at random
    function automatic mtks_pkg::t_in_item tick_ev();
        mtks_pkg::t_in_item it;
        it    = IN_W'($urandom);
        it.op = 1'b1;
        return it;
    endfunction

    function automatic mtks_pkg::t_out_item rep(input logic [4:0] idx,
                                                input logic [7:0] cnt,
                                                input logic [2:0] kind);
        mtks_pkg::t_out_item r;
        r             = '0;
        r.is_action   = 1'b1;
        r.key_index   = idx;
        r.tap_count   = cnt;
        r.action_kind = kind;
        return r;
    endfunction

    function automatic mtks_pkg::t_out_item verdict(input logic fwd);
        mtks_pkg::t_out_item r;
        r             = '0;
        r.forward_key = fwd;
        return r;
    endfunction

    function automatic logic [15:0] pick_code(input logic [15:0] base);
        logic [15:0] k;
        if ($urandom_range(0, 99) < 85) begin
            k = 16'($urandom_range(0, 31));
            return base + k;
        end
        return 16'($urandom);
    endfunction

    function automatic logic rare();
        return $urandom_range(0, 99) < 5;
    endfunction

    task automatic pin_ev(input mtks_pkg::t_in_item it, input int n,
                          input mtks_pkg::t_out_item a, input mtks_pkg::t_out_item b,
                          input mtks_pkg::t_out_item c);
        t_step s;
        s            = '0;
        s.item       = it;
        s.pin.pinned = 1'b1;
        s.pin.n      = 2'(n);
        s.pin.r[0]   = a;
        s.pin.r[1]   = b;
        s.pin.r[2]   = c;
        if (n > 0)
            s.pin.r[n - 1].last_item = 1'b1;
        plan.push_back(s);
    endtask

    task automatic free_ev(input mtks_pkg::t_in_item it);
        t_step s;
        s      = '0;
        s.item = it;
        plan.push_back(s);
    endtask

    task automatic plan_cfg(input logic idx, input logic [15:0] val);
        t_step s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = val;
        plan.push_back(s);
    endtask

    task automatic send(input mtks_pkg::t_in_item it, input t_pin pin);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        pin_q.push_back(pin);
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ev_sent++;
    endtask

    // drain everything, then cover ticks that complete without a transfer
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // press / hold / release rounds on one key, at times with another key tapped inside, ticks in between
    task automatic play_burst(input logic [15:0] base, input logic [15:0] tmo);
        logic [15:0] code;
        logic [15:0] other;
        int          rounds;
        int          tick_max;
        code     = pick_code(base);
        rounds   = $urandom_range(1, 3);
        tick_max = (tmo < 16'd8) ? int'(tmo) + 2 : 3;
        for (int t = 0; t < rounds; t++) begin
            send(key_ev(code, 1'b1, 1'b0, rare()), '0);
            repeat ($urandom_range(0, 2)) send(key_ev(code, 1'b1, 1'b1, rare()), '0);
            if ($urandom_range(0, 99) < 15) begin
                other = pick_code(base);
                send(key_ev(other, 1'b1, 1'b0, rare()), '0);
                send(key_ev(other, 1'b0, 1'b1, rare()), '0);
            end
            send(key_ev(code, 1'b0, 1'b1, rare()), '0);
            repeat ($urandom_range(0, tick_max)) send(tick_ev(), '0);
        end
    endtask

    initial begin
        logic [15:0]        ph_code [6];
        logic [15:0]        ph_tmo [6];
        mtks_pkg::t_in_item it;
        int                 quota;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= mtks_pkg::CFG_FIRST_CODE;
        i_cfg_data  <= '0;
        calm    = 1'b0;
        ev_sent = 0;

        // directed part, starting from reset values
        pin_ev(tick_ev(), 0, NIL, NIL, NIL);
        pin_ev(key_ev(16'd5, 1'b1, 1'b0, 1'b1), 1, verdict(1'b1), NIL, NIL);
        pin_ev(key_ev(16'h1234, 1'b0, 1'b0, 1'b0), 1, verdict(1'b1), NIL, NIL);
        pin_ev(key_ev(16'd3, 1'b0, 1'b0, 1'b0), 1, verdict(1'b0), NIL, NIL);
        pin_ev(key_ev(16'd31, 1'b1, 1'b0, 1'b0), 2,
               rep(5'd31, 8'd1, mtks_pkg::KIND_TAP), verdict(1'b0), NIL);
        pin_ev(key_ev(16'd31, 1'b0, 1'b1, 1'b0), 1, verdict(1'b0), NIL, NIL);
        pin_ev(key_ev(16'd0, 1'b1, 1'b0, 1'b0), 3,
               rep(5'd31, 8'd1, mtks_pkg::KIND_INTERRUPT),
               rep(5'd0, 8'd1, mtks_pkg::KIND_TAP), verdict(1'b0));
        pin_ev(key_ev(16'd0, 1'b1, 1'b1, 1'b0), 2,
               rep(5'd0, 8'd1, mtks_pkg::KIND_HOLD), verdict(1'b0), NIL);
        pin_ev(key_ev(16'hFFFF, 1'b1, 1'b0, 1'b0), 2,
               rep(5'd0, 8'd1, mtks_pkg::KIND_INTERRUPT), verdict(1'b1), NIL);
        pin_ev(key_ev(16'd31, 1'b0, 1'b1, 1'b0), 2,
               rep(5'd31, 8'd2, mtks_pkg::KIND_TAP), verdict(1'b0), NIL);
        pin_ev(key_ev(16'd0, 1'b0, 1'b1, 1'b0), 2,
               rep(5'd0, 8'd1, mtks_pkg::KIND_RELEASE), verdict(1'b0), NIL);
        pin_ev(key_ev(16'd0, 1'b0, 1'b1, 1'b0), 1, verdict(1'b0), NIL, NIL);
        pin_ev(key_ev(16'd0, 1'b1, 1'b1, 1'b0), 1, verdict(1'b0), NIL, NIL);
        pin_ev(key_ev(16'hFFFF, 1'b1, 1'b1, 1'b0), 1, verdict(1'b1), NIL, NIL);
        free_ev(tick_ev());
        plan_cfg(mtks_pkg::CFG_TIMEOUT_TICKS, 16'd0);
        pin_ev(tick_ev(), 1, rep(5'd31, 8'd2, mtks_pkg::KIND_TIMEOUT), NIL, NIL);
        pin_ev(tick_ev(), 0, NIL, NIL, NIL);
        plan_cfg(mtks_pkg::CFG_FIRST_CODE, 16'd65530);
        pin_ev(key_ev(16'hFFFF, 1'b1, 1'b0, 1'b0), 2,
               rep(5'd5, 8'd1, mtks_pkg::KIND_TAP), verdict(1'b0), NIL);
        pin_ev(key_ev(16'd0, 1'b1, 1'b0, 1'b0), 2,
               rep(5'd5, 8'd1, mtks_pkg::KIND_INTERRUPT), verdict(1'b1), NIL);
        pin_ev(key_ev(16'd65529, 1'b0, 1'b0, 1'b0), 1, verdict(1'b1), NIL, NIL);
        plan_cfg(mtks_pkg::CFG_TIMEOUT_TICKS, 16'hFFFF);
        plan_cfg(mtks_pkg::CFG_FIRST_CODE, 16'hFFFF);
        free_ev(key_ev(16'hFFFF, 1'b1, 1'b0, 1'b0));
        free_ev(tick_ev());
        free_ev(key_ev(16'hFFFF, 1'b1, 1'b1, 1'b0));
        free_ev(key_ev(16'hFFFE, 1'b1, 1'b0, 1'b0));
        free_ev(key_ev(16'hFFFF, 1'b0, 1'b1, 1'b0));

        ph_code[0] = 16'd0;            ph_tmo[0] = 16'd3;
        ph_code[1] = 16'hFFFF;         ph_tmo[1] = 16'd1;
        ph_code[2] = 16'd65520;        ph_tmo[2] = 16'd0;
        ph_code[3] = 16'($urandom);    ph_tmo[3] = 16'($urandom_range(2, 5));
        ph_code[4] = 16'd100;          ph_tmo[4] = 16'hFFFF;
        ph_code[5] = 16'($urandom);    ph_tmo[5] = 16'd4;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                settle();
                write_cfg(plan[k].cfg_idx, plan[k].cfg_val);
            end else begin
                send(plan[k].item, plan[k].pin);
            end
        end

        for (int p = 0; p < 6; p++) begin
            settle();
            write_cfg(mtks_pkg::CFG_FIRST_CODE, ph_code[p]);
            write_cfg(mtks_pkg::CFG_TIMEOUT_TICKS, ph_tmo[p]);
            // last phase runs with no idling on either side
            calm  = (p == 5);
            quota = ev_sent + 60;
            while (ev_sent < quota) begin
                if ($urandom_range(0, 99) < 20) begin
                    it          = IN_W'($urandom);
                    it.op       = ($urandom_range(0, 3) == 0);
                    if ($urandom_range(0, 1))
                        it.key_code = pick_code(ph_code[p]);
                    send(it, '0);
                end else begin
                    play_burst(ph_code[p], ph_tmo[p]);
                end
            end
        end

        settle();
        if (errs == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: multi_tap_key_sequencer.f
hw/rtl/mtks_pkg.sv
hw/rtl/mtks_step.sv
hw/rtl/multi_tap_key_sequencer.sv
dv/tb.sv
